[rtl/ctc_pkg.sv]
// ---------------------------------------------------------------------------
// ctc_pkg
// types and constants shared by the trace classifier modules
// ---------------------------------------------------------------------------
package ctc_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int VALUE_BITS_DEF = 16;
    localparam int IN_VALUE_W     = 16;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [2:0] VERDICT_UNSURE = 3'd0;
    localparam logic [2:0] VERDICT_STACK  = 3'd1;
    localparam logic [2:0] VERDICT_QUEUE  = 3'd2;
    localparam logic [2:0] VERDICT_PRIO   = 3'd3;
    localparam logic [2:0] VERDICT_NONE   = 3'd4;

    typedef struct packed {
        logic                  command;
        logic [IN_VALUE_W-1:0] value;
        logic                  first_of_case;
    } t_in_word;

    typedef struct packed {
        logic [2:0] verdict;
        logic       overflow;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic read;
        logic exec;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic busy;
    } t_status;

endpackage

[rtl/ctc_ram.sv]
// ---------------------------------------------------------------------------
// ctc_ram
// generic simple dual port ram with registered read
// ---------------------------------------------------------------------------
module ctc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/ctc_sorted.sv]
// ---------------------------------------------------------------------------
// ctc_sorted
// systolic sorted chain, largest entry in cell zero
// ---------------------------------------------------------------------------
module ctc_sorted #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_push,
    input  logic                  i_pop,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic [VALUE_BITS-1:0] o_top,
    output logic                  o_top_valid
);
    logic [VALUE_BITS-1:0] r_val [DEPTH];
    logic [DEPTH-1:0]      r_occ;
    logic [DEPTH-1:0]      w_ge;

    // cells holding values at least the new one keep their place
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            w_ge[k] = r_occ[k] && (r_val[k] >= i_value);
        end
    end

    // occupancy is a thermometer code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_occ <= '0;
        end else if (i_push) begin
            r_occ <= {r_occ[DEPTH-2:0], 1'b1};
        end else if (i_pop) begin
            r_occ <= {1'b0, r_occ[DEPTH-1:1]};
        end
    end

    // each cell looks only at its neighbors
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            if (i_push) begin
                if (!w_ge[k]) begin
                    if (k == 0) begin
                        r_val[k] <= i_value;
                    end else if (w_ge[k-1]) begin
                        r_val[k] <= i_value;
                    end else begin
                        r_val[k] <= r_val[k-1];
                    end
                end
            end else if (i_pop && k < DEPTH-1) begin
                r_val[k] <= r_val[k+1];
            end
        end
    end

    assign o_top       = r_val[0];
    assign o_top_valid = r_occ[0];
endmodule

[rtl/ctc_datapath.sv]
// ---------------------------------------------------------------------------
// ctc_datapath
// stack, queue and sorted chain models with their possible flags
// ---------------------------------------------------------------------------
module ctc_datapath #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctc_pkg::t_cmd     i_cmd,
    input  ctc_pkg::t_in_word i_word,
    output ctc_pkg::t_out_word o_word,
    output ctc_pkg::t_status  o_status
);
    import ctc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic                  r_cmd;
    logic [VALUE_BITS-1:0] r_val;
    logic [CW-1:0]         r_scnt;
    logic [CW-1:0]         r_qcnt;
    logic [CW-1:0]         r_pcnt;
    logic [AW-1:0]         r_head;
    logic [AW-1:0]         r_tail;
    logic [2:0]            r_poss;
    logic [2:0]            n_poss;
    logic                  n_ovf;
    t_out_word             r_word;
    t_out_word             n_word;
    logic [VALUE_BITS-1:0] w_stop;
    logic [VALUE_BITS-1:0] w_qtop;
    logic [VALUE_BITS-1:0] w_ptop;
    logic                  w_pvalid;
    logic [AW-1:0]         w_sraddr;
    logic                  w_spush, w_spop, w_qpush, w_qpop, w_ppush, w_ppop;
    logic [1:0]            w_cnt;

    // sorted chain fill count kept alongside for the full test
    function automatic logic r_occ_full();
        return r_pcnt == FULL;
    endfunction

    // latch the word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_word.command;
            r_val <= VALUE_BITS'(i_word.value);
        end
    end

    assign w_sraddr = (r_scnt == '0) ? '0 : AW'(r_scnt - CW'(1));

    ctc_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(w_spush), .i_waddr(r_scnt[AW-1:0]),
        .i_wdata(r_val), .i_raddr(w_sraddr), .o_rdata(w_stop)
    );

    ctc_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_queue (
        .i_clk(i_clk), .i_we(w_qpush), .i_waddr(r_tail),
        .i_wdata(r_val), .i_raddr(r_head), .o_rdata(w_qtop)
    );

    ctc_sorted #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_sorted (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(i_cmd.clear),
        .i_push(w_ppush), .i_pop(w_ppop), .i_value(r_val),
        .o_top(w_ptop), .o_top_valid(w_pvalid)
    );

    // model decisions in the exec step
    always_comb begin
        w_spush = 1'b0; w_spop = 1'b0; w_qpush = 1'b0;
        w_qpop = 1'b0; w_ppush = 1'b0; w_ppop = 1'b0;
        n_poss = r_poss;
        n_ovf = 1'b0;
        if (i_cmd.exec) begin
            if (r_cmd == CMD_PUSH) begin
                if (r_poss[0]) begin
                    if (r_scnt == FULL) begin n_poss[0] = 1'b0; n_ovf = 1'b1; end
                    else w_spush = 1'b1;
                end
                if (r_poss[1]) begin
                    if (r_qcnt == FULL) begin n_poss[1] = 1'b0; n_ovf = 1'b1; end
                    else w_qpush = 1'b1;
                end
                if (r_poss[2]) begin
                    if (r_occ_full()) begin n_poss[2] = 1'b0; n_ovf = 1'b1; end
                    else w_ppush = 1'b1;
                end
            end else begin
                if (r_poss[0]) begin
                    if (r_scnt == '0 || w_stop != r_val) n_poss[0] = 1'b0;
                    else w_spop = 1'b1;
                end
                if (r_poss[1]) begin
                    if (r_qcnt == '0 || w_qtop != r_val) n_poss[1] = 1'b0;
                    else w_qpop = 1'b1;
                end
                if (r_poss[2]) begin
                    if (!w_pvalid || w_ptop != r_val) n_poss[2] = 1'b0;
                    else w_ppop = 1'b1;
                end
            end
        end
    end

    // counters, pointers and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_scnt <= '0; r_qcnt <= '0; r_pcnt <= '0;
            r_head <= '0; r_tail <= '0;
            r_poss <= 3'b111;
        end else if (i_cmd.exec) begin
            r_poss <= n_poss;
            if (w_spush) r_scnt <= r_scnt + CW'(1);
            if (w_spop)  r_scnt <= r_scnt - CW'(1);
            if (w_qpush) begin
                r_tail <= (r_tail == LAST) ? '0 : r_tail + AW'(1);
                r_qcnt <= r_qcnt + CW'(1);
            end
            if (w_qpop) begin
                r_head <= (r_head == LAST) ? '0 : r_head + AW'(1);
                r_qcnt <= r_qcnt - CW'(1);
            end
            if (w_ppush) r_pcnt <= r_pcnt + CW'(1);
            if (w_ppop)  r_pcnt <= r_pcnt - CW'(1);
        end
    end

    // verdict from the updated flags
    assign w_cnt = 2'(n_poss[0]) + 2'(n_poss[1]) + 2'(n_poss[2]);
    always_comb begin
        if (w_cnt > 2'd1)   n_word.verdict = VERDICT_UNSURE;
        else if (n_poss[0]) n_word.verdict = VERDICT_STACK;
        else if (n_poss[1]) n_word.verdict = VERDICT_QUEUE;
        else if (n_poss[2]) n_word.verdict = VERDICT_PRIO;
        else                n_word.verdict = VERDICT_NONE;
        n_word.overflow = n_ovf;
    end

    // result register, written at exec
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_word <= n_word;
        end
    end

    assign o_word          = r_word;
    assign o_status.busy   = i_cmd.read;
endmodule

[rtl/ctc_ctrl.sv]
// ---------------------------------------------------------------------------
// ctc_ctrl
// sequencer: load, read stores, execute into the result register
// ---------------------------------------------------------------------------
module ctc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_first,
    input  logic             i_out_ready,
    input  ctc_pkg::t_status i_status,
    output logic             o_ready,
    output logic             o_valid,
    output ctc_pkg::t_cmd    o_cmd
);
    import ctc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // state and result valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands; exec waits for a free result register
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_ready     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state = i_status.busy ? ST_EXEC : ST_READ;
            end
            ST_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (o_ready && i_valid) begin
            o_cmd.load  = 1'b1;
            o_cmd.clear = i_first;
            n_state     = ST_READ;
        end
    end

    assign o_valid = r_out_valid;
endmodule

[rtl/container_trace_classifier.sv]
// ---------------------------------------------------------------------------
// container_trace_classifier
// classifies push/pop traces as stack, queue or priority queue
// ---------------------------------------------------------------------------
// channel  direction  handshake        payload
// in       input      i_valid/o_ready  t_in_word
// out      output     o_valid/i_ready  t_out_word
//
// each word passes load, store read and execute in turn; the result word
// is registered at execute and offered the cycle after.
// the store read step lets the stack and queue rams deliver their registered read.
// the next word may enter the cycle after execute, while a result waits.
// reset clears counts and flags at once, no clearing pass.
// a stalled result holds the following word in its execute state.
// ---------------------------------------------------------------------------
module container_trace_classifier #(
    parameter int DEPTH      = ctc_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = ctc_pkg::VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ctc_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output ctc_pkg::t_out_word o_data
);
    import ctc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    ctc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_first(i_data.first_of_case), .i_out_ready(i_ready),
        .i_status(w_status), .o_ready(o_ready), .o_valid(o_valid), .o_cmd(w_cmd)
    );

    ctc_datapath #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_word(i_data),
        .o_word(o_data), .o_status(w_status)
    );

    // a word is never loaded during exec
    a_no_load_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |-> !w_cmd.load) else $error("load during exec");
    // exec is always followed by a valid result
    a_exec_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |=> o_valid) else $error("no result after exec");
    // a waiting result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result word dropped or changed");
endmodule

[tb/container_trace_classifier_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// container_trace_classifier_test
// checks the trace classifier against its own stack, queue and sorted model;
// a short directed table comes first, then random traces, most of them
// well-formed for one container kind, plus one long case that overflows
// ---------------------------------------------------------------------------
module container_trace_classifier_test;
    import ctc_pkg::*;

    localparam int DEPTH       = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int POSS_STACK  = 0;
    localparam int POSS_QUEUE  = 1;
    localparam int POSS_PRIO   = 2;
    localparam int KIND_STACK  = 0;
    localparam int KIND_QUEUE  = 1;
    localparam int KIND_PRIO   = 2;
    localparam int KIND_NOISE  = 3;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_word  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_word o_data;

    container_trace_classifier dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #5 i_clk = ~i_clk;

    // classifier model state
    logic [15:0] lifo_mem [DEPTH];
    int          lifo_cnt;
    logic [15:0] fifo_mem [DEPTH];
    int          fifo_rd, fifo_wr, fifo_cnt;
    logic [15:0] sort_mem [DEPTH];
    int          sort_cnt;
    logic [2:0]  alive;

    t_out_word   verdict_q [$];
    t_out_word   typed_word;
    logic        typed_valid = 1'b0;
    int          fail_cnt = 0;
    int          cycles = 0;
    int          idle_pct = 31;
    int          hold_left = 0;

    function automatic void clear_models();
        lifo_cnt = 0; fifo_rd = 0; fifo_wr = 0; fifo_cnt = 0; sort_cnt = 0;
        alive = 3'b111;
    endfunction

    function automatic t_out_word classify(t_in_word w);
        t_out_word r;
        int pos;
        if (w.first_of_case) clear_models();
        r.overflow = 1'b0;
        if (w.command == CMD_PUSH) begin
            if (alive[POSS_STACK]) begin
                if (lifo_cnt >= DEPTH) begin
                    alive[POSS_STACK] = 1'b0; r.overflow = 1'b1;
                end else begin
                    lifo_mem[lifo_cnt] = w.value; lifo_cnt++;
                end
            end
            if (alive[POSS_QUEUE]) begin
                if (fifo_cnt >= DEPTH) begin
                    alive[POSS_QUEUE] = 1'b0; r.overflow = 1'b1;
                end else begin
                    fifo_mem[fifo_wr] = w.value;
                    fifo_wr = (fifo_wr + 1) % DEPTH; fifo_cnt++;
                end
            end
            if (alive[POSS_PRIO]) begin
                if (sort_cnt >= DEPTH) begin
                    alive[POSS_PRIO] = 1'b0; r.overflow = 1'b1;
                end else begin
                    // descending order, new word goes after its equals
                    pos = 0;
                    while (pos < sort_cnt && sort_mem[pos] >= w.value) pos++;
                    for (int i = sort_cnt; i > pos; i--) sort_mem[i] = sort_mem[i-1];
                    sort_mem[pos] = w.value; sort_cnt++;
                end
            end
        end else begin
            if (alive[POSS_STACK]) begin
                if (lifo_cnt == 0 || lifo_mem[lifo_cnt-1] != w.value)
                    alive[POSS_STACK] = 1'b0;
                else
                    lifo_cnt--;
            end
            if (alive[POSS_QUEUE]) begin
                if (fifo_cnt == 0 || fifo_mem[fifo_rd] != w.value) begin
                    alive[POSS_QUEUE] = 1'b0;
                end else begin
                    fifo_rd = (fifo_rd + 1) % DEPTH; fifo_cnt--;
                end
            end
            if (alive[POSS_PRIO]) begin
                if (sort_cnt == 0 || sort_mem[0] != w.value) begin
                    alive[POSS_PRIO] = 1'b0;
                end else begin
                    for (int i = 1; i < sort_cnt; i++) sort_mem[i-1] = sort_mem[i];
                    sort_cnt--;
                end
            end
        end
        if (alive[0] + alive[1] + alive[2] > 1) r.verdict = VERDICT_UNSURE;
        else if (alive[POSS_STACK])             r.verdict = VERDICT_STACK;
        else if (alive[POSS_QUEUE])             r.verdict = VERDICT_QUEUE;
        else if (alive[POSS_PRIO])              r.verdict = VERDICT_PRIO;
        else                                    r.verdict = VERDICT_NONE;
        return r;
    endfunction

    // accepted words feed the model, delivered words are checked
    always @(posedge i_clk) begin
        t_out_word exp_w;
        t_out_word got_w;
        cycles <= cycles + 1;
        if (i_rst_n && i_valid && o_ready) begin
            exp_w = classify(i_data);
            verdict_q.push_back(typed_valid ? typed_word : exp_w);
        end
        if (i_rst_n && o_valid && i_ready) begin
            got_w = o_data;
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected word verdict=%0d overflow=%0d",
                         $time, got_w.verdict, got_w.overflow);
                fail_cnt++;
            end else begin
                exp_w = verdict_q.pop_front();
                if (got_w.verdict != exp_w.verdict) begin
                    $display("%0t: verdict expected %0d got %0d",
                             $time, exp_w.verdict, got_w.verdict);
                    fail_cnt++;
                end
                if (got_w.overflow != exp_w.overflow) begin
                    $display("%0t: overflow expected %0d got %0d",
                             $time, exp_w.overflow, got_w.overflow);
                    fail_cnt++;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_word(logic cmd, logic [15:0] val, logic first);
        t_in_word w;
        w.command = cmd; w.value = val; w.first_of_case = first;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // one case of random content shaped to fit one container kind
    task automatic send_case(int kind, int len, int val_max);
        int held [$];
        int v, k, best;
        for (int n = 0; n < len; n++) begin
            if (held.size() == 0 || $urandom_range(99) < 50) begin
                v = (val_max < 0) ? $urandom_range(65535) : $urandom_range(val_max);
                held.push_back(v);
                send_word(CMD_PUSH, v[15:0], n == 0);
            end else if (kind == KIND_NOISE || $urandom_range(99) < 5) begin
                v = $urandom_range(99) < 50 ? held[$urandom_range(held.size()-1)]
                                            : $urandom_range(65535);
                send_word(CMD_POP, v[15:0], n == 0);
            end else begin
                case (kind)
                    KIND_STACK: k = held.size() - 1;
                    KIND_QUEUE: k = 0;
                    default: begin
                        k = 0; best = held[0];
                        foreach (held[j]) if (held[j] > best) begin
                            best = held[j]; k = j;
                        end
                    end
                endcase
                v = held[k];
                held.delete(k);
                send_word(CMD_POP, v[15:0], n == 0);
            end
        end
    endtask

    typedef struct {
        logic       cmd;
        logic [15:0] val;
        logic       first;
        logic       typed;
        logic [2:0] verdict;
        logic       overflow;
    } t_row;

    t_row plan [] = '{
        '{CMD_PUSH, 16'd5,     1'b1, 1'b1, VERDICT_UNSURE, 1'b0},
        '{CMD_POP,  16'd5,     1'b0, 1'b1, VERDICT_UNSURE, 1'b0},
        '{CMD_POP,  16'd7,     1'b0, 1'b1, VERDICT_NONE,   1'b0},
        '{CMD_PUSH, 16'd1,     1'b1, 1'b1, VERDICT_UNSURE, 1'b0},
        '{CMD_PUSH, 16'd2,     1'b0, 1'b1, VERDICT_UNSURE, 1'b0},
        '{CMD_POP,  16'd2,     1'b0, 1'b0, VERDICT_UNSURE, 1'b0},
        '{CMD_POP,  16'd1,     1'b0, 1'b0, VERDICT_UNSURE, 1'b0},
        '{CMD_PUSH, 16'd1,     1'b1, 1'b0, VERDICT_UNSURE, 1'b0},
        '{CMD_PUSH, 16'd2,     1'b0, 1'b0, VERDICT_UNSURE, 1'b0},
        '{CMD_POP,  16'd1,     1'b0, 1'b0, VERDICT_UNSURE, 1'b0},
        '{CMD_PUSH, 16'd3,     1'b1, 1'b0, VERDICT_UNSURE, 1'b0},
        '{CMD_PUSH, 16'd9,     1'b0, 1'b0, VERDICT_UNSURE, 1'b0},
        '{CMD_PUSH, 16'd4,     1'b0, 1'b0, VERDICT_UNSURE, 1'b0},
        '{CMD_POP,  16'd9,     1'b0, 1'b0, VERDICT_UNSURE, 1'b0},
        '{CMD_PUSH, 16'd4,     1'b1, 1'b0, VERDICT_UNSURE, 1'b0},
        '{CMD_PUSH, 16'd6,     1'b0, 1'b0, VERDICT_UNSURE, 1'b0},
        '{CMD_PUSH, 16'd5,     1'b0, 1'b0, VERDICT_UNSURE, 1'b0},
        '{CMD_POP,  16'd5,     1'b0, 1'b0, VERDICT_UNSURE, 1'b0},
        '{CMD_PUSH, 16'hffff,  1'b1, 1'b1, VERDICT_UNSURE, 1'b0},
        '{CMD_PUSH, 16'h0000,  1'b0, 1'b1, VERDICT_UNSURE, 1'b0},
        '{CMD_POP,  16'hffff,  1'b0, 1'b0, VERDICT_UNSURE, 1'b0},
        '{CMD_POP,  16'h0000,  1'b0, 1'b0, VERDICT_UNSURE, 1'b0}
    };

    // stimulus
    initial begin
        int kind;
        clear_models();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // typed expectations change with each driven word, set before it is offered
        foreach (plan[r]) begin
            typed_valid         <= plan[r].typed;
            typed_word.verdict  <= plan[r].verdict;
            typed_word.overflow <= plan[r].overflow;
            send_word(plan[r].cmd, plan[r].val, plan[r].first);
        end
        typed_valid <= 1'b0;

        // receiver holds off while the sender keeps offering words
        hold_left = 300;
        send_case(KIND_STACK, 20, -1);

        // long case that fills every model and overflows, no idling here
        idle_pct = 0;
        for (int n = 0; n < DEPTH + 3; n++)
            send_word(CMD_PUSH, 16'($urandom_range(65535)), n == 0);
        send_word(CMD_POP, 16'($urandom_range(65535)), 1'b0);
        idle_pct = 31;

        for (int c = 0; c < 30; c++) begin
            kind = $urandom_range(99) < 20 ? KIND_NOISE : $urandom_range(KIND_PRIO);
            send_case(kind, $urandom_range(1, 24), $urandom_range(99) < 50 ? 7 : -1);
        end
        i_valid <= 1'b0;

        wait (verdict_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
rtl/ctc_pkg.sv
rtl/ctc_ram.sv
rtl/ctc_sorted.sv
rtl/ctc_datapath.sv
rtl/ctc_ctrl.sv
rtl/container_trace_classifier.sv
tb/container_trace_classifier_test.sv
